// ===== src/mciir_pkg.sv =====
// Shared types and constants of the multichannel IIR filter.
package mciir_pkg;

   localparam int CHAN_W    = 5;
   localparam int SAMPLE_W  = 24;
   localparam int COEFF_W   = 24;
   localparam int FRAC_W    = 22;
   localparam int ORDER_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int TDATA_W   = 32;
   localparam int PROD_W    = SAMPLE_W + COEFF_W;
   localparam int ACC_W     = PROD_W + 3;
   localparam int QUO_W     = ACC_W - FRAC_W;

   localparam int SAT_MAX = 8388607;
   localparam int SAT_MIN = -8388608;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORDER = 3'd0,
      REG_B0    = 3'd1,
      REG_B1    = 3'd2,
      REG_B2    = 3'd3,
      REG_A1    = 3'd4,
      REG_A2    = 3'd5
   } csr_reg_type;

   localparam logic [ORDER_W-1:0]        ORDER_RST = 2'd2;
   localparam logic signed [COEFF_W-1:0] B0_RST    = 24'sd152447;
   localparam logic signed [COEFF_W-1:0] B1_RST    = 24'sd0;
   localparam logic signed [COEFF_W-1:0] B2_RST    = -24'sd152447;
   localparam logic signed [COEFF_W-1:0] A1_RST    = -24'sd8073500;
   localparam logic signed [COEFF_W-1:0] A2_RST    = 24'sd3889411;

   typedef struct packed {
      logic signed [COEFF_W-1:0] b0;
      logic signed [COEFF_W-1:0] b1;
      logic signed [COEFF_W-1:0] b2;
      logic signed [COEFF_W-1:0] a1;
      logic signed [COEFF_W-1:0] a2;
      logic                      order2;
   } coeff_type;

endpackage

// ===== src/multichannel_iir_filter.sv =====
// Top level of the multichannel direct form I biquad filter.
//
// Direct form I IIR filter of order 1 or 2, time-shared by CHANNELS channels.
// Each req transfer carries one sample of one channel; each rsp transfer
// returns that channel's filtered sample, y = b0*x + b1*x1 + b2*x2 - a1*y1
// - a2*y2, with Q2.22 coefficients, rounded half up and saturated to 24 bits.
// Throughput is one sample per clock cycle while rsp_tready stays high, also
// for the same channel on consecutive cycles; a sample enters the stage
// register at its transfer and is loaded into the result register when the
// stage advances. The cycle is set by the single compute
// stage: five 24x24 multiplies, their sum, rounding and saturation. Per-
// channel history lives in one RAM row per channel, read at the transfer
// edge; a back-to-back sample of the same channel gets the freshly computed
// row forwarded instead. One valid bit per row stands for the all-zero reset
// state, so no clearing pass follows reset. Channels at or above CHANNELS are
// filtered against zero history and leave all history untouched.
// filter_order 0 acts as 1, 3 as 2, and the order is limited to MAX_ORDER.
// Write coefficients only while no sample is in flight.
module multichannel_iir_filter #(
   parameter int CHANNELS  = 32,
   parameter int MAX_ORDER = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: channel [4:0], sample [28:5], zero padding above
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mciir_pkg::TDATA_W-1:0]       req_tdata,
   // rsp_tdata: out_channel [4:0], filtered [28:5], zero padding above
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mciir_pkg::TDATA_W-1:0]       rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mciir_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mciir_pkg::COEFF_W-1:0]       csr_wdata
);

   localparam int CHAN_W   = mciir_pkg::CHAN_W;
   localparam int SAMPLE_W = mciir_pkg::SAMPLE_W;
   localparam int COEFF_W  = mciir_pkg::COEFF_W;
   localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   // a row always has room for two taps; deeper orders store more
   localparam int ROW_N    = (MAX_ORDER > 2) ? MAX_ORDER : 2;
   localparam int ROW_W    = 2 * ROW_N * SAMPLE_W;
   localparam int PAD_W    = mciir_pkg::TDATA_W - CHAN_W - SAMPLE_W;
   localparam logic [CHAN_W+1:0] CH_LIMIT = (CHAN_W+2)'(CHANNELS);

   // ---------------- configuration registers ----------------
   logic [mciir_pkg::ORDER_W-1:0] order_ff;
   logic signed [COEFF_W-1:0]     b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   mciir_pkg::coeff_type          coeff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= mciir_pkg::ORDER_RST;
         b0_ff    <= mciir_pkg::B0_RST;
         b1_ff    <= mciir_pkg::B1_RST;
         b2_ff    <= mciir_pkg::B2_RST;
         a1_ff    <= mciir_pkg::A1_RST;
         a2_ff    <= mciir_pkg::A2_RST;
      end else if (csr_valid) begin
         unique case (mciir_pkg::csr_reg_type'(csr_index))
            mciir_pkg::REG_ORDER: order_ff <= csr_wdata[mciir_pkg::ORDER_W-1:0];
            mciir_pkg::REG_B0:    b0_ff    <= csr_wdata;
            mciir_pkg::REG_B1:    b1_ff    <= csr_wdata;
            mciir_pkg::REG_B2:    b2_ff    <= csr_wdata;
            mciir_pkg::REG_A1:    a1_ff    <= csr_wdata;
            mciir_pkg::REG_A2:    a2_ff    <= csr_wdata;
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   // second-order terms only for order codes 2 and 3, and only if built in
   always_comb begin
      coeff.b0     = b0_ff;
      coeff.b1     = b1_ff;
      coeff.b2     = b2_ff;
      coeff.a1     = a1_ff;
      coeff.a2     = a2_ff;
      coeff.order2 = order_ff[1] && (MAX_ORDER >= 2);
   end

   // ---------------- handshake and flow control ----------------
   logic                       stage_valid_ff, stage_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       stage_adv, req_fire;

   // the stage moves on when the result register is empty or drains now
   assign stage_adv  = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || stage_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (stage_adv) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (stage_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // ---------------- incoming transfer ----------------
   logic [CHAN_W-1:0]          req_chan;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic [CH_AW-1:0]           req_addr;
   logic                       req_in_range;

   assign req_chan     = req_tdata[CHAN_W-1:0];
   assign req_sample   = req_tdata[CHAN_W +: SAMPLE_W];
   assign req_addr     = CH_AW'(req_chan);
   assign req_in_range = {2'b00, req_chan} < CH_LIMIT;

   // ---------------- stage register ----------------
   logic [CHAN_W-1:0]          stage_chan_ff;
   logic signed [SAMPLE_W-1:0] stage_sample_ff;
   logic [CH_AW-1:0]           stage_addr_ff;
   logic                       stage_in_range_ff;
   logic                       hit_ff;       // row was written since reset
   logic                       use_byp_ff;   // take forwarded row, not RAM
   logic [ROW_W-1:0]           byp_row_ff;
   logic [CHANNELS-1:0]        row_valid_ff;

   logic                       hist_we, fwd;
   logic [ROW_W-1:0]           ram_rdata, cur_row, new_row;
   logic signed [SAMPLE_W-1:0] filtered;

   // write back the shifted history as the sample leaves the stage
   assign hist_we = stage_adv && stage_in_range_ff;
   // same channel right behind: RAM read would miss this write
   assign fwd     = hist_we && req_in_range && (req_addr == stage_addr_ff);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_chan_ff     <= req_chan;
         stage_sample_ff   <= req_sample;
         stage_addr_ff     <= req_addr;
         stage_in_range_ff <= req_in_range;
         hit_ff            <= req_in_range && row_valid_ff[req_addr];
         use_byp_ff        <= fwd;
         byp_row_ff        <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (hist_we) begin
         row_valid_ff[stage_addr_ff] <= 1'b1;
      end
   end

   mciir_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CHANNELS)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (stage_addr_ff),
      .wdata (new_row),
      .re    (req_fire),
      .raddr (req_addr),
      .rdata (ram_rdata)
   );

   // row layout: inputs x1..xN in the low half, outputs y1..yN above
   always_comb begin
      if (use_byp_ff) begin
         cur_row = byp_row_ff;
      end else if (hit_ff) begin
         cur_row = ram_rdata;
      end else begin
         cur_row = '0;
      end
   end

   mciir_calc u_calc (
      .coeff    (coeff),
      .sample   (stage_sample_ff),
      .x1       (cur_row[0 +: SAMPLE_W]),
      .x2       (cur_row[SAMPLE_W +: SAMPLE_W]),
      .y1       (cur_row[ROW_N*SAMPLE_W +: SAMPLE_W]),
      .y2       (cur_row[(ROW_N+1)*SAMPLE_W +: SAMPLE_W]),
      .filtered (filtered)
   );

   // advance both delay lines by one tap
   always_comb begin
      new_row[0 +: SAMPLE_W]              = stage_sample_ff;
      new_row[ROW_N*SAMPLE_W +: SAMPLE_W] = filtered;
      for (int k = 1; k < ROW_N; k++) begin
         new_row[k*SAMPLE_W +: SAMPLE_W] = cur_row[(k-1)*SAMPLE_W +: SAMPLE_W];
         new_row[(ROW_N+k)*SAMPLE_W +: SAMPLE_W] =
            cur_row[(ROW_N+k-1)*SAMPLE_W +: SAMPLE_W];
      end
   end

   // ---------------- result register ----------------
   logic [CHAN_W-1:0]   rsp_chan_ff;
   logic [SAMPLE_W-1:0] rsp_filt_ff;

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         rsp_chan_ff <= stage_chan_ff;
         rsp_filt_ff <= filtered;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_filt_ff, rsp_chan_ff};

`ifndef SYNTHESIS
   // a stalled stage keeps its sample
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_adv |=> stage_valid_ff && $stable(stage_chan_ff)
         && $stable(stage_sample_ff))
      else $error("stage sample changed while stalled");

   // forwarding only ever serves an in-range channel in a live stage entry
   a_byp_live: assert property (@(posedge clock) disable iff (reset)
      use_byp_ff && stage_valid_ff |-> stage_in_range_ff)
      else $error("forwarded row for out-of-range channel");

   // every history write loads a result
   a_write_result: assert property (@(posedge clock) disable iff (reset)
      hist_we |=> rsp_valid_ff)
      else $error("history written without a result");

   // an accepted transfer occupies the stage next cycle
   a_accept_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> stage_valid_ff)
      else $error("accepted sample lost");
`endif

endmodule

// ===== src/mciir_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mciir_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/mciir_calc.sv =====
// Biquad arithmetic: five products, sum, round to nearest and saturate.
module mciir_calc (
   input  mciir_pkg::coeff_type                         coeff,
   input  logic signed [mciir_pkg::SAMPLE_W-1:0]        sample,
   input  logic signed [mciir_pkg::SAMPLE_W-1:0]        x1,
   input  logic signed [mciir_pkg::SAMPLE_W-1:0]        x2,
   input  logic signed [mciir_pkg::SAMPLE_W-1:0]        y1,
   input  logic signed [mciir_pkg::SAMPLE_W-1:0]        y2,
   output logic signed [mciir_pkg::SAMPLE_W-1:0]        filtered
);

   localparam int ACC_W = mciir_pkg::ACC_W;
   localparam int QUO_W = mciir_pkg::QUO_W;
   localparam int FRAC_W = mciir_pkg::FRAC_W;
   localparam logic signed [ACC_W-1:0] HALF_LSB =
      $signed({{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
   localparam logic signed [QUO_W-1:0] Q_MAX = QUO_W'(mciir_pkg::SAT_MAX);
   localparam logic signed [QUO_W-1:0] Q_MIN = QUO_W'(mciir_pkg::SAT_MIN);

   logic signed [mciir_pkg::PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [ACC_W-1:0]             acc, rnd;
   logic signed [QUO_W-1:0]             quo;

   assign p_b0 = $signed(coeff.b0) * sample;
   assign p_b1 = $signed(coeff.b1) * x1;
   assign p_b2 = $signed(coeff.b2) * x2;
   assign p_a1 = $signed(coeff.a1) * y1;
   assign p_a2 = $signed(coeff.a2) * y2;

   always_comb begin
      acc = ACC_W'(p_b0) + ACC_W'(p_b1) - ACC_W'(p_a1);
      if (coeff.order2) begin
         acc = acc + ACC_W'(p_b2) - ACC_W'(p_a2);
      end
      // round half up, then drop the fraction
      rnd = acc + HALF_LSB;
      quo = rnd[ACC_W-1:FRAC_W];
      if (quo > Q_MAX) begin
         filtered = Q_MAX[mciir_pkg::SAMPLE_W-1:0];
      end else if (quo < Q_MIN) begin
         filtered = Q_MIN[mciir_pkg::SAMPLE_W-1:0];
      end else begin
         filtered = quo[mciir_pkg::SAMPLE_W-1:0];
      end
   end

endmodule
